// ===== hw/rtl/mmp2_pkg.sv =====
package mmp2_pkg;

    localparam int WORD_W   = 31;
    localparam int EXP_BITS = 31;
    localparam int BIT_W    = $clog2(EXP_BITS);
    localparam int CNT_W    = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] MODULUS_RESET = WORD_W'(1234567891);

    typedef struct packed {
        logic [WORD_W-1:0] in_top_left;
        logic [WORD_W-1:0] in_top_right;
        logic [WORD_W-1:0] in_bottom_left;
        logic [WORD_W-1:0] in_bottom_right;
        logic [WORD_W-1:0] exponent;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_top_left;
        logic [WORD_W-1:0] out_top_right;
        logic [WORD_W-1:0] out_bottom_left;
        logic [WORD_W-1:0] out_bottom_right;
    } out_word_t;

    // job for the modular multiply-accumulate unit:
    // result = (op_a * str_b + op_c * str_d + str_x) mod modulus
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_c;
        logic [WORD_W-1:0] str_b;
        logic [WORD_W-1:0] str_d;
        logic [WORD_W-1:0] str_x;
    } mac_cmd_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } mac_rsp_t;

endpackage

// ===== hw/rtl/mmp2_mac.sv =====
module mmp2_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mmp2_pkg::WORD_W-1:0]   modulus,
    input  mmp2_pkg::mac_cmd_t            cmd,
    output mmp2_pkg::mac_rsp_t            rsp
);
    import mmp2_pkg::*;

    localparam int T_W = WORD_W + 3;

    logic [WORD_W-1:0] r_reg, a_reg, c_reg, b_sh_reg, d_sh_reg, x_sh_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    logic [T_W-1:0] t, m1, m2, m3, sub, r_wide;

    // one MSB-first step: r = (2r + x + b*a + d*c) mod m, with r, a, c below m
    always_comb begin
        m1 = {3'b000, modulus};
        m2 = {2'b00, modulus, 1'b0};
        m3 = m1 + m2;
        t  = {2'b00, r_reg, 1'b0} + T_W'(x_sh_reg[WORD_W-1])
           + (b_sh_reg[WORD_W-1] ? {3'b000, a_reg} : '0)
           + (d_sh_reg[WORD_W-1] ? {3'b000, c_reg} : '0);
        if (t >= m3) begin
            sub = m3;
        end else if (t >= m2) begin
            sub = m2;
        end else if (t >= m1) begin
            sub = m1;
        end else begin
            sub = '0;
        end
        r_wide = t - sub;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(WORD_W - 1);
            r_reg    <= '0;
            a_reg    <= cmd.op_a;
            c_reg    <= cmd.op_c;
            b_sh_reg <= cmd.str_b;
            d_sh_reg <= cmd.str_d;
            x_sh_reg <= cmd.str_x;
        end else if (busy_reg) begin
            r_reg    <= r_wide[WORD_W-1:0];
            b_sh_reg <= {b_sh_reg[WORD_W-2:0], 1'b0};
            d_sh_reg <= {d_sh_reg[WORD_W-2:0], 1'b0};
            x_sh_reg <= {x_sh_reg[WORD_W-2:0], 1'b0};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

// ===== hw/rtl/mod_matrix_power_2x2_unit.sv =====
// 2x2 matrix power modulo a programmable modulus (cfg word, reset 1234567891).
// Entries are first reduced mod the modulus, then square-and-multiply runs over
// the exponent bits from the top; exponent zero returns the identity, modulus
// zero or one returns all zeros. Every entry of every product goes through one
// bit-serial modular multiply-accumulate unit. An item is accepted, its four
// entries are reduced, then each exponent bit gets a squaring and, if set, a
// multiply, and the result is handed over; squarings start only after the
// highest set exponent bit and the first multiply is a copy. Modulus zero skips
// the work and goes straight to the hand-over. s_ready is high only while no
// item is being worked on; a finished result waits in the output register
// while the next item is accepted and worked on, and that item's result waits
// until the register is free.
module mod_matrix_power_2x2_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mmp2_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mmp2_pkg::out_word_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mmp2_pkg::WORD_W-1:0]   cfg_data
);
    import mmp2_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_BIT,
        ST_MULCHK,
        ST_ADV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_REDUCE,
        PH_SQUARE,
        PH_MULT
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [1:0]        entry_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              acc_id_reg;
    logic [WORD_W-1:0] mod_reg;
    logic [WORD_W-1:0] exp_reg;
    logic [WORD_W-1:0] base_reg [4];
    logic [WORD_W-1:0] acc_reg  [4];
    logic [WORD_W-1:0] new_reg  [4];
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic [WORD_W-1:0] p [4];
    mac_cmd_t          cmd;
    mac_rsp_t          rsp;

    mmp2_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (mod_reg),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    // left operand: acc for squaring, base for multiply; right operand is acc
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p[k] = (phase_reg == PH_SQUARE) ? acc_reg[k] : base_reg[k];
        end
        cmd.start = (state_reg == ST_ISSUE);
        cmd.op_a  = '0;
        cmd.op_c  = '0;
        cmd.str_b = '0;
        cmd.str_d = '0;
        cmd.str_x = '0;
        if (phase_reg == PH_REDUCE) begin
            case (entry_reg)
                2'd0:    cmd.str_x = base_reg[0];
                2'd1:    cmd.str_x = base_reg[1];
                2'd2:    cmd.str_x = base_reg[2];
                default: cmd.str_x = base_reg[3];
            endcase
        end else begin
            case (entry_reg)
                2'd0: begin
                    cmd.op_a  = p[0];
                    cmd.op_c  = p[1];
                    cmd.str_b = acc_reg[0];
                    cmd.str_d = acc_reg[2];
                end
                2'd1: begin
                    cmd.op_a  = p[0];
                    cmd.op_c  = p[1];
                    cmd.str_b = acc_reg[1];
                    cmd.str_d = acc_reg[3];
                end
                2'd2: begin
                    cmd.op_a  = p[2];
                    cmd.op_c  = p[3];
                    cmd.str_b = acc_reg[0];
                    cmd.str_d = acc_reg[2];
                end
                default: begin
                    cmd.op_a  = p[2];
                    cmd.op_c  = p[3];
                    cmd.str_b = acc_reg[1];
                    cmd.str_d = acc_reg[3];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_REDUCE;
            m_valid_reg <= 1'b0;
            mod_reg     <= MODULUS_RESET;
        end else begin
            if (cfg_valid) begin
                mod_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        base_reg[0] <= s_data.in_top_left;
                        base_reg[1] <= s_data.in_top_right;
                        base_reg[2] <= s_data.in_bottom_left;
                        base_reg[3] <= s_data.in_bottom_right;
                        exp_reg     <= s_data.exponent;
                        acc_reg[1]  <= '0;
                        acc_reg[2]  <= '0;
                        acc_id_reg  <= 1'b1;
                        phase_reg   <= PH_REDUCE;
                        entry_reg   <= 2'd0;
                        if (mod_reg == '0) begin
                            acc_reg[0] <= '0;
                            acc_reg[3] <= '0;
                            state_reg  <= ST_OUT;
                        end else begin
                            acc_reg[0] <= (mod_reg == WORD_W'(1)) ? '0 : WORD_W'(1);
                            acc_reg[3] <= (mod_reg == WORD_W'(1)) ? '0 : WORD_W'(1);
                            state_reg  <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (rsp.done) begin
                        if (phase_reg == PH_REDUCE) begin
                            base_reg[entry_reg] <= rsp.result;
                        end else begin
                            new_reg[entry_reg] <= rsp.result;
                        end
                        if (entry_reg != 2'd3) begin
                            entry_reg <= entry_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end else begin
                            entry_reg <= 2'd0;
                            case (phase_reg)
                                PH_REDUCE: begin
                                    bit_reg   <= BIT_W'(EXP_BITS - 1);
                                    state_reg <= ST_BIT;
                                end
                                PH_SQUARE: begin
                                    acc_reg[0] <= new_reg[0];
                                    acc_reg[1] <= new_reg[1];
                                    acc_reg[2] <= new_reg[2];
                                    acc_reg[3] <= rsp.result;
                                    state_reg  <= ST_MULCHK;
                                end
                                default: begin
                                    acc_reg[0] <= new_reg[0];
                                    acc_reg[1] <= new_reg[1];
                                    acc_reg[2] <= new_reg[2];
                                    acc_reg[3] <= rsp.result;
                                    state_reg  <= ST_ADV;
                                end
                            endcase
                        end
                    end
                end
                ST_BIT: begin
                    // squaring the identity changes nothing
                    if (acc_id_reg) begin
                        state_reg <= ST_MULCHK;
                    end else begin
                        phase_reg <= PH_SQUARE;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_MULCHK: begin
                    if (!exp_reg[bit_reg]) begin
                        state_reg <= ST_ADV;
                    end else if (acc_id_reg) begin
                        acc_reg[0] <= base_reg[0];
                        acc_reg[1] <= base_reg[1];
                        acc_reg[2] <= base_reg[2];
                        acc_reg[3] <= base_reg[3];
                        acc_id_reg <= 1'b0;
                        state_reg  <= ST_ADV;
                    end else begin
                        phase_reg <= PH_MULT;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ADV: begin
                    if (bit_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= ST_BIT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_top_left     <= acc_reg[0];
                        m_data_reg.out_top_right    <= acc_reg[1];
                        m_data_reg.out_bottom_left  <= acc_reg[2];
                        m_data_reg.out_bottom_right <= acc_reg[3];
                        m_valid_reg                 <= 1'b1;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import mmp2_pkg::*;

    typedef struct packed {
        logic [63:0] e11;
        logic [63:0] e12;
        logic [63:0] e21;
        logic [63:0] e22;
    } mat64_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_word_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_word_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data  = '0;

    in_word_t          pending_q [$];
    out_word_t         power_q [$];
    logic [WORD_W-1:0] modulus_now;

    int send_gap, send_burst, recv_wait, recv_burst, hold_left;
    bit hold_req, hold_done;
    int n_accepted, n_checked, n_mismatch, n_settings;

    always #1 aclk = ~aclk;

    mod_matrix_power_2x2_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic mat64_t mat_mul_mod(mat64_t p, mat64_t q, logic [63:0] md);
        mat64_t r;
        r.e11 = (p.e11 * q.e11 + p.e12 * q.e21) % md;
        r.e12 = (p.e11 * q.e12 + p.e12 * q.e22) % md;
        r.e21 = (p.e21 * q.e11 + p.e22 * q.e21) % md;
        r.e22 = (p.e21 * q.e12 + p.e22 * q.e22) % md;
        return r;
    endfunction

    function automatic out_word_t matrix_power(in_word_t w, logic [WORD_W-1:0] m);
        logic [63:0] md;
        logic [63:0] n;
        mat64_t      base;
        mat64_t      acc;
        out_word_t   r;
        int          b;
        md = 64'(m);
        n  = 64'(w.exponent);
        r  = '0;
        if (md == 64'd0) begin
            return r;
        end
        base.e11 = 64'(w.in_top_left) % md;
        base.e12 = 64'(w.in_top_right) % md;
        base.e21 = 64'(w.in_bottom_left) % md;
        base.e22 = 64'(w.in_bottom_right) % md;
        acc.e11  = 64'd1 % md;
        acc.e12  = 64'd0;
        acc.e21  = 64'd0;
        acc.e22  = 64'd1 % md;
        for (b = EXP_BITS - 1; b >= 0; b--) begin
            acc = mat_mul_mod(acc, acc, md);
            if (((n >> b) & 64'd1) != 64'd0) begin
                acc = mat_mul_mod(base, acc, md);
            end
        end
        r.out_top_left     = acc.e11[WORD_W-1:0];
        r.out_top_right    = acc.e12[WORD_W-1:0];
        r.out_bottom_left  = acc.e21[WORD_W-1:0];
        r.out_bottom_right = acc.e22[WORD_W-1:0];
        return r;
    endfunction

    // runs of back-to-back words now and then, otherwise a random idle gap
    function automatic int pick_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 48);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [WORD_W-1:0] pick_entry(logic [WORD_W-1:0] m);
        case ($urandom_range(0, 7))
            0: begin
                return WORD_W'($urandom_range(0, 3));
            end
            1: begin
                return '1;
            end
            2: begin
                return m - WORD_W'($urandom_range(0, 1));
            end
            3: begin
                return m + WORD_W'($urandom_range(1, 2));
            end
            default: begin
                return WORD_W'($urandom);
            end
        endcase
    endfunction

    // mostly short exponents; full width only now and then, as those are slow
    function automatic logic [WORD_W-1:0] pick_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return WORD_W'($urandom_range(0, 15));
        end
        if (r < 88) begin
            return WORD_W'($urandom_range(0, 255));
        end
        if (r < 97) begin
            return WORD_W'($urandom_range(0, 65535));
        end
        return WORD_W'($urandom);
    endfunction

    task automatic add_word(input in_word_t w);
        pending_q.insert(pending_q.size(), w);
    endtask

    task automatic queue_random(input int count);
        in_word_t w;
        repeat (count) begin
            w.in_top_left     = pick_entry(modulus_now);
            w.in_top_right    = pick_entry(modulus_now);
            w.in_bottom_left  = pick_entry(modulus_now);
            w.in_bottom_right = pick_entry(modulus_now);
            w.exponent        = pick_exponent();
            add_word(w);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || power_q.size() != 0);
    endtask

    task automatic set_modulus(input logic [WORD_W-1:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        modulus_now = v;
        n_settings++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                power_q.insert(power_q.size(), matrix_power(s_data, modulus_now));
                n_accepted <= n_accepted + 1;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_data   <= pending_q.pop_front();
                s_valid  <= 1'b1;
                send_gap <= pick_wait(send_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        int        w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            w = recv_wait;
            if (m_valid && m_ready) begin
                if (power_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result word with nothing outstanding: %h %h %h %h",
                                 m_data.out_top_left, m_data.out_top_right,
                                 m_data.out_bottom_left, m_data.out_bottom_right);
                    end
                end else begin
                    want = power_q.pop_front();
                    n_checked++;
                    if (want.out_top_left     !== m_data.out_top_left  ||
                        want.out_top_right    !== m_data.out_top_right ||
                        want.out_bottom_left  !== m_data.out_bottom_left ||
                        want.out_bottom_right !== m_data.out_bottom_right) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch on result %0d: expected %h %h %h %h, got %h %h %h %h",
                                     n_checked, want.out_top_left, want.out_top_right,
                                     want.out_bottom_left, want.out_bottom_right,
                                     m_data.out_top_left, m_data.out_top_right,
                                     m_data.out_bottom_left, m_data.out_bottom_right);
                        end
                    end
                end
                w = pick_wait(recv_burst);
            end else if (w > 0) begin
                w--;
            end
            recv_wait <= w;
            m_ready   <= (w == 0) && (hold_left == 0);
        end
    end

    // long back-pressure on the result side so the output word and the next item
    // both wait and s_ready stays low
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= 20000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        logic [WORD_W-1:0] mod_seq [$];
        modulus_now = MODULUS_RESET;
        mod_seq = '{31'h7FFF_FFFF, 31'd2, 31'd0, 31'd1, 31'd3, 31'd1_000_000_007,
                    31'd65536, 31'h7FFF_FFFE};
        mod_seq.insert(mod_seq.size(), WORD_W'($urandom_range(2, 32'h7FFF_FFFF)));
        mod_seq.insert(mod_seq.size(), WORD_W'($urandom_range(2, 4095)));
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed set under the reset modulus
        add_word(in_word_t'{31'd0, 31'd0, 31'd0, 31'd0, 31'd0});
        add_word(in_word_t'{'1, '1, '1, '1, 31'd0});
        add_word(in_word_t'{'1, '1, '1, '1, 31'd1});
        add_word(in_word_t'{'1, '1, '1, '1, '1});
        add_word(in_word_t'{31'd0, 31'd0, 31'd0, 31'd0, 31'd1});
        add_word(in_word_t'{31'd0, 31'd0, 31'd0, 31'd0, 31'd5});
        add_word(in_word_t'{31'd1, 31'd1, 31'd1, 31'd0, 31'd10});
        add_word(in_word_t'{31'd1, 31'd1, 31'd1, 31'd0, 31'h4000_0000});
        add_word(in_word_t'{31'd1, 31'd1, 31'd1, 31'd0, '1});
        add_word(in_word_t'{MODULUS_RESET, MODULUS_RESET, MODULUS_RESET,
                            MODULUS_RESET, 31'd2});
        add_word(in_word_t'{MODULUS_RESET - WORD_W'(1), MODULUS_RESET - WORD_W'(1),
                            MODULUS_RESET - WORD_W'(1), MODULUS_RESET - WORD_W'(1),
                            31'd3});
        add_word(in_word_t'{31'd2, 31'd0, 31'd0, 31'd2, 31'd30});
        add_word(in_word_t'{31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA,
                            31'h5555_5555, 31'h2AAA_AAAA});
        add_word(in_word_t'{31'd7, 31'd3, 31'd11, 31'd5, 31'd2});
        queue_random(150);
        wait_drained();

        foreach (mod_seq[i]) begin
            set_modulus(mod_seq[i]);
            queue_random(170);
            if (i == 0) begin
                hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (9000) @(posedge aclk);
        $display("Raised %0d matrices to a power and compared %0d result words,",
                 n_accepted, n_checked);
        $display("under the reset modulus and %0d written ones, zero and one among them.",
                 n_settings);
        if (n_mismatch == 0 && power_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #150_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
